>>> rtl/core/pahp_pkg.sv
// Shared types, constants and register codes of the process alarm with peak hold.
package pahp_pkg;

  localparam int PV_W         = 16;
  localparam int SUM_W        = PV_W + 2;
  localparam int MODE_W       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 40;
  localparam int STANDBY_BAND = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF      = 4'd0,
    MODE_REL_BOTH = 4'd1,
    MODE_REL_HIGH = 4'd2,
    MODE_REL_LOW  = 4'd3,
    MODE_ABS_BOTH = 4'd4,
    MODE_ABS_HIGH = 4'd5,
    MODE_ABS_LOW  = 4'd6,
    MODE_HYS_HIGH = 4'd7,
    MODE_HYS_LOW  = 4'd8
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM_MODE     = 3'd0,
    REG_SETPOINT       = 3'd1,
    REG_HIGH_LIMIT     = 3'd2,
    REG_LOW_LIMIT      = 3'd3,
    REG_STANDBY_ENABLE = 3'd4,
    REG_INVERT_ENABLE  = 3'd5,
    REG_HOLD_ENABLE    = 3'd6,
    REG_PEAK_ENABLE    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0]      alarm_mode;
    logic signed [PV_W-1:0] setpoint;
    logic signed [PV_W-1:0] high_limit;
    logic signed [PV_W-1:0] low_limit;
    logic                   standby_enable;
    logic                   invert_enable;
    logic                   hold_enable;
    logic                   peak_enable;
  } cfg_t;

  typedef struct packed {
    logic                   alarm_latch;
    logic                   standby_ready;
    logic signed [PV_W-1:0] peak_high;
    logic signed [PV_W-1:0] peak_low;
  } state_t;

endpackage

>>> rtl/core/process_alarm_with_peak_hold_core.sv
// Top level of the process alarm with peak hold: ports, configuration, stages and state.
// The block takes one process value request per clock and returns one result per request,
// in order. A request is captured in an input register. While it is held there and the
// output register can take a result, one short stage evaluates it, updates the alarm
// latch, standby flag and peaks, and loads the result into the output register, which
// holds it until taken. The sustained rate is one request per cycle as long as the
// result side keeps taking. Configuration is written through a plain indexed write port;
// the user must write it only while no request is in flight; the core does not enforce it.
module process_alarm_with_peak_hold_core import pahp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] process_value, [16] clear_latch, [17] clear_peaks, [23:18] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] alarm_out, [16:1] peak_high_out, [32:17] peak_low_out, [39:33] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t                   cfg_r;
  logic                   in_valid_r;
  logic [IN_TDATA_W-1:0]  in_data_r;
  state_t                 state_r;
  state_t                 state_nxt;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   alarm;
  logic                   advance;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ALARM_MODE:     cfg_r.alarm_mode     <= cfg_wdata[MODE_W-1:0];
        REG_SETPOINT:       cfg_r.setpoint       <= cfg_wdata[PV_W-1:0];
        REG_HIGH_LIMIT:     cfg_r.high_limit     <= cfg_wdata[PV_W-1:0];
        REG_LOW_LIMIT:      cfg_r.low_limit      <= cfg_wdata[PV_W-1:0];
        REG_STANDBY_ENABLE: cfg_r.standby_enable <= cfg_wdata[0];
        REG_INVERT_ENABLE:  cfg_r.invert_enable  <= cfg_wdata[0];
        REG_HOLD_ENABLE:    cfg_r.hold_enable    <= cfg_wdata[0];
        REG_PEAK_ENABLE:    cfg_r.peak_enable    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pahp_eval u_eval (
    .cfg_i       (cfg_r),
    .state_i     (state_r),
    .pv_i        (in_data_r[PV_W-1:0]),
    .clr_latch_i (in_data_r[PV_W]),
    .clr_peaks_i (in_data_r[PV_W+1]),
    .state_o     (state_nxt),
    .alarm_o     (alarm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
    end
    if (advance) begin
      out_data_r <= {(OUT_TDATA_W - 2*PV_W - 1)'(0), state_nxt.peak_low,
                     state_nxt.peak_high, alarm};
    end
  end

endmodule

>>> rtl/core/pahp_eval.sv
// Combinational evaluation of one sample: peaks, standby, alarm mode, hold and invert.
module pahp_eval import pahp_pkg::*; (
  input  cfg_t                   cfg_i,
  input  state_t                 state_i,
  input  logic signed [PV_W-1:0] pv_i,
  input  logic                   clr_latch_i,
  input  logic                   clr_peaks_i,
  output state_t                 state_o,
  output logic                   alarm_o
);

  localparam logic signed [SUM_W-1:0] BAND = SUM_W'(STANDBY_BAND);

  logic signed [SUM_W-1:0] pv_x;
  logic signed [SUM_W-1:0] sp_x;
  logic signed [SUM_W-1:0] hi_x;
  logic signed [SUM_W-1:0] lo_x;
  logic signed [SUM_W-1:0] sp_plus_hi;
  logic signed [SUM_W-1:0] sp_minus_lo;
  logic signed [SUM_W-1:0] sp_plus_lo;
  logic signed [SUM_W-1:0] sp_minus_hi;
  logic                    in_band;
  logic signed [PV_W-1:0]  ph0;
  logic signed [PV_W-1:0]  pl0;
  logic                    latch0;
  logic                    latch1;
  logic                    ready1;
  logic                    raw_alarm;
  logic                    held_alarm;
  logic                    latch2;

  assign pv_x        = SUM_W'(pv_i);
  assign sp_x        = SUM_W'(cfg_i.setpoint);
  assign hi_x        = SUM_W'(cfg_i.high_limit);
  assign lo_x        = SUM_W'(cfg_i.low_limit);
  assign sp_plus_hi  = sp_x + hi_x;
  assign sp_minus_lo = sp_x - lo_x;
  assign sp_plus_lo  = sp_x + lo_x;
  assign sp_minus_hi = sp_x - hi_x;
  assign in_band     = (pv_x >= sp_x - BAND) && (pv_x <= sp_x + BAND);

  assign latch0 = clr_latch_i ? 1'b0 : state_i.alarm_latch;
  assign ph0    = clr_peaks_i ? pv_i : state_i.peak_high;
  assign pl0    = clr_peaks_i ? pv_i : state_i.peak_low;
  assign ready1 = cfg_i.standby_enable ? (state_i.standby_ready | in_band) : 1'b1;

  always_comb begin
    raw_alarm = 1'b0;
    latch1    = latch0;
    if (ready1) begin
      unique case (cfg_i.alarm_mode)
        MODE_REL_BOTH: raw_alarm = (pv_x > sp_plus_hi) || (pv_x < sp_minus_lo);
        MODE_REL_HIGH: raw_alarm = pv_x > sp_plus_hi;
        MODE_REL_LOW:  raw_alarm = pv_x < sp_minus_lo;
        MODE_ABS_BOTH: raw_alarm = (pv_x > hi_x) || (pv_x < lo_x);
        MODE_ABS_HIGH: raw_alarm = pv_x > hi_x;
        MODE_ABS_LOW:  raw_alarm = pv_x < lo_x;
        MODE_HYS_HIGH: begin
          latch1    = latch0 ? !(pv_x < sp_plus_lo) : (pv_x > sp_plus_hi);
          raw_alarm = latch1;
        end
        MODE_HYS_LOW: begin
          latch1    = latch0 ? !(pv_x > sp_minus_lo) : (pv_x < sp_minus_hi);
          raw_alarm = latch1;
        end
        default: raw_alarm = 1'b0;
      endcase
    end
  end

  assign latch2     = cfg_i.hold_enable ? (latch1 | raw_alarm) : latch1;
  assign held_alarm = cfg_i.hold_enable ? latch2 : raw_alarm;
  assign alarm_o    = held_alarm ^ cfg_i.invert_enable;

  always_comb begin
    state_o.alarm_latch   = latch2;
    state_o.standby_ready = ready1;
    state_o.peak_high     = ph0;
    state_o.peak_low      = pl0;
    if (cfg_i.peak_enable) begin
      if (ph0 < pv_i) state_o.peak_high = pv_i;
      if (pl0 > pv_i) state_o.peak_low  = pv_i;
    end
  end

endmodule

>>> rtl/core/pahp_checker.sv
// Port-level assertions of the process alarm with peak hold, bound to the top level.
module pahp_checker import pahp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic signed [PV_W-1:0] peak_high;
  logic signed [PV_W-1:0] peak_low;

  assign peak_high = out_tdata[PV_W:1];
  assign peak_low  = out_tdata[2*PV_W:PV_W+1];

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid directly after reset.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or dropped.");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("Input stalled although the result side is free.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:2*PV_W+1] == '0)
    else $error("Result padding bits are not zero.");

  a_peak_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> peak_low <= peak_high)
    else $error("Peak low exceeds peak high.");

endmodule

bind process_alarm_with_peak_hold_core pahp_checker u_pahp_checker (.*);

>>> bench/process_alarm_with_peak_hold_checker.sv
`timescale 1ns / 100ps
// Checker for the process alarm core: watches all ports, predicts each result and compares.
module process_alarm_with_peak_hold_checker import pahp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen
);

  localparam int MAX_PRINTED = 200;

  typedef struct {
    logic                   alarm;
    logic signed [PV_W-1:0] peak_hi;
    logic signed [PV_W-1:0] peak_lo;
  } reading_t;

  cfg_t     regs;
  state_t   st;
  reading_t expected_readings[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("Mismatch on result %0d: %s is %0d, expected %0d.", results_seen, what, got,
               want);
    end
  endtask

  function automatic reading_t predict_reading(input logic signed [PV_W-1:0] pv,
                                               input logic clr_latch,
                                               input logic clr_peaks);
    reading_t                r;
    logic signed [SUM_W-1:0] pvx;
    logic signed [SUM_W-1:0] sp;
    logic signed [SUM_W-1:0] hl;
    logic signed [SUM_W-1:0] ll;
    logic [MODE_W-1:0]       mode;
    logic                    alarm;
    pvx   = pv;
    sp    = regs.setpoint;
    hl    = regs.high_limit;
    ll    = regs.low_limit;
    mode  = regs.alarm_mode;
    alarm = 1'b0;
    if (clr_latch) st.alarm_latch = 1'b0;
    if (clr_peaks) begin
      st.peak_high = pv;
      st.peak_low  = pv;
    end
    if (regs.peak_enable) begin
      if (st.peak_high < pv) st.peak_high = pv;
      if (st.peak_low > pv) st.peak_low = pv;
    end
    if (!regs.standby_enable) begin
      st.standby_ready = 1'b1;
    end else if (pvx >= sp - STANDBY_BAND && pvx <= sp + STANDBY_BAND) begin
      st.standby_ready = 1'b1;
    end
    if (!st.standby_ready) mode = MODE_OFF;
    case (mode)
      MODE_REL_BOTH: alarm = (pvx > sp + hl) || (pvx < sp - ll);
      MODE_REL_HIGH: alarm = pvx > sp + hl;
      MODE_REL_LOW:  alarm = pvx < sp - ll;
      MODE_ABS_BOTH: alarm = (pvx > hl) || (pvx < ll);
      MODE_ABS_HIGH: alarm = pvx > hl;
      MODE_ABS_LOW:  alarm = pvx < ll;
      MODE_HYS_HIGH: begin
        if (st.alarm_latch) begin
          if (pvx < sp + ll) st.alarm_latch = 1'b0;
        end else if (pvx > sp + hl) begin
          st.alarm_latch = 1'b1;
        end
        alarm = st.alarm_latch;
      end
      MODE_HYS_LOW: begin
        if (st.alarm_latch) begin
          if (pvx > sp - ll) st.alarm_latch = 1'b0;
        end else if (pvx < sp - hl) begin
          st.alarm_latch = 1'b1;
        end
        alarm = st.alarm_latch;
      end
      default: alarm = 1'b0;
    endcase
    if (regs.hold_enable) begin
      if (alarm) st.alarm_latch = 1'b1;
      alarm = st.alarm_latch;
    end
    if (regs.invert_enable) alarm = !alarm;
    r.alarm   = alarm;
    r.peak_hi = st.peak_high;
    r.peak_lo = st.peak_low;
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t               want;
    logic signed [PV_W-1:0] hi_got;
    logic signed [PV_W-1:0] lo_got;
    if (!rst_n) begin
      regs = '0;
      st   = '0;
      expected_readings.delete();
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALARM_MODE:     regs.alarm_mode     = cfg_wdata[MODE_W-1:0];
          REG_SETPOINT:       regs.setpoint       = cfg_wdata;
          REG_HIGH_LIMIT:     regs.high_limit     = cfg_wdata;
          REG_LOW_LIMIT:      regs.low_limit      = cfg_wdata;
          REG_STANDBY_ENABLE: regs.standby_enable = cfg_wdata[0];
          REG_INVERT_ENABLE:  regs.invert_enable  = cfg_wdata[0];
          REG_HOLD_ENABLE:    regs.hold_enable    = cfg_wdata[0];
          REG_PEAK_ENABLE:    regs.peak_enable    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_readings.size() == 0) begin
          report_mismatch("result with no request waiting, count", 1, 0);
        end else begin
          want   = expected_readings.pop_front();
          hi_got = out_tdata[16:1];
          lo_got = out_tdata[32:17];
          if (out_tdata[0] !== want.alarm) report_mismatch("alarm_out", out_tdata[0], want.alarm);
          if (hi_got !== want.peak_hi) report_mismatch("peak_high_out", hi_got, want.peak_hi);
          if (lo_got !== want.peak_lo) report_mismatch("peak_low_out", lo_got, want.peak_lo);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_readings.push_back(predict_reading(in_tdata[15:0], in_tdata[16], in_tdata[17]));
      end
      pending = expected_readings.size();
    end
  end

endmodule

>>> bench/tb_process_alarm_with_peak_hold_core.sv
`timescale 1ns / 100ps
// Testbench top for the process alarm core: clock, reset, stimulus, idle patterns and verdict.
module tb_process_alarm_with_peak_hold_core;
  import pahp_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int ROUNDS_PER_PHASE = 3;
  localparam int ITEMS_PER_ROUND  = 85;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int fail_count;
  int pending;
  int results_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_requests;
  int hold_off_served = 0;
  int hold_left = 0;
  int requests_sent;
  int settings_used;
  int quiet_cycles = 0;

  process_alarm_with_peak_hold_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  process_alarm_with_peak_hold_checker alarm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (hold_off_requests != hold_off_served) begin
      hold_off_served = hold_off_requests;
      hold_left       = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Nothing moved for %0d cycles; %0d results still outstanding.", quiet_cycles,
               pending);
      $display("[process_alarm_with_peak_hold_core] ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic [PV_W-1:0] pv, input logic clr_latch,
                           input logic clr_peaks);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, clr_peaks, clr_latch, pv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input cfg_t c);
    logic [PV_W-1:0] pv;
    int              pick;
    pick = $urandom_range(15);
    if (pick == 0) pv = 16'h7FFF;
    else if (pick == 1) pv = 16'h8000;
    else if (pick < 5) pv = PV_W'($urandom);
    else pv = c.setpoint + PV_W'(int'($urandom_range(600)) - 300);
    send_item(pv, $urandom_range(19) == 0, $urandom_range(19) == 0);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_ALARM_MODE, CFG_DATA_W'(c.alarm_mode));
    write_reg(REG_SETPOINT, c.setpoint);
    write_reg(REG_HIGH_LIMIT, c.high_limit);
    write_reg(REG_LOW_LIMIT, c.low_limit);
    write_reg(REG_STANDBY_ENABLE, CFG_DATA_W'(c.standby_enable));
    write_reg(REG_INVERT_ENABLE, CFG_DATA_W'(c.invert_enable));
    write_reg(REG_HOLD_ENABLE, CFG_DATA_W'(c.hold_enable));
    write_reg(REG_PEAK_ENABLE, CFG_DATA_W'(c.peak_enable));
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    if ($urandom_range(9) == 0) c.alarm_mode = MODE_W'($urandom_range(15));
    else c.alarm_mode = MODE_W'($urandom_range(8, 1));
    if ($urandom_range(5) == 0) c.setpoint = PV_W'($urandom);
    else c.setpoint = PV_W'(int'($urandom_range(2000)) - 1000);
    if ($urandom_range(5) == 0) c.high_limit = PV_W'($urandom);
    else c.high_limit = PV_W'(int'($urandom_range(400)) - 100);
    if ($urandom_range(5) == 0) c.low_limit = PV_W'($urandom);
    else c.low_limit = PV_W'(int'($urandom_range(400)) - 100);
    c.standby_enable = ($urandom_range(2) == 0);
    c.invert_enable  = 1'($urandom_range(1));
    c.hold_enable    = ($urandom_range(2) == 0);
    c.peak_enable    = ($urandom_range(3) != 0);
    return c;
  endfunction

  initial begin
    cfg_t c;
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_off_requests = 0;
    requests_sent     = 0;
    settings_used     = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every mode code, including an unused one, at extreme setpoints and limits.
    for (int m = 0; m <= 9; m++) begin
      c                = '0;
      c.alarm_mode     = (m == 9) ? MODE_W'(15) : MODE_W'(m);
      c.setpoint       = m[0] ? 16'sh7FFF : 16'sh8000;
      c.high_limit     = m[1] ? 16'sh7FFF : 16'sh8000;
      c.low_limit      = m[1] ? 16'sh8000 : 16'sh7FFF;
      c.hold_enable    = m[2];
      c.invert_enable  = m[3] || (m == 9);
      c.peak_enable    = !m[2];
      apply_config(c);
      send_item(16'h7FFF, 1'b0, 1'b1);
      send_item(16'h8000, 1'b1, 1'b0);
      drain();
    end

    // Standby holds the alarm off until the value enters the band around the setpoint.
    c                = '0;
    c.alarm_mode     = MODE_ABS_HIGH;
    c.setpoint       = 16'sd1000;
    c.standby_enable = 1'b1;
    c.hold_enable    = 1'b1;
    c.peak_enable    = 1'b1;
    apply_config(c);
    send_item(16'd5000, 1'b0, 1'b1);
    send_item(16'd989, 1'b0, 1'b0);
    send_item(16'd990, 1'b0, 1'b0);
    send_item(-16'sd5, 1'b1, 1'b0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int round = 0; round < ROUNDS_PER_PHASE; round++) begin
        c = random_config();
        apply_config(c);
        if (phase == 0 && round == 1) hold_off_requests++;
        repeat (ITEMS_PER_ROUND) send_random(c);
        drain();
      end
    end

    $display("Sent %0d requests and checked %0d results across %0d register settings.",
             requests_sent, results_seen, settings_used);
    $display("Run covered every alarm mode, standby, hold, invert, peaks and four idle mixes.");
    if (fail_count == 0) begin
      $display("[process_alarm_with_peak_hold_core] OK");
    end else begin
      $display("[process_alarm_with_peak_hold_core] ERROR");
    end
    $finish;
  end

endmodule
